@@ hw/rtl/quaternion_vector_rotation_unit_defines.svh @@
// Assertion macros for the quaternion vector rotation unit checker.
`ifndef QUATERNION_VECTOR_ROTATION_UNIT_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATION_UNIT_DEFINES_SVH

// Clocked property, masked during reset.
`define QVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, also checked through reset.
`define QVR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/qvr_pkg.sv @@
// Widths and latencies shared by the quaternion rotation unit.
`default_nettype none
package qvr_pkg;
  localparam int QUAT_WIDTH = 16;
  localparam int VEC_WIDTH  = 32;
  // matrix entry: sum of four pair products, doubled
  localparam int MAT_WIDTH  = 2 * QUAT_WIDTH + 2;
  localparam int PROD_WIDTH = MAT_WIDTH + VEC_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + 2;
  localparam int NRM_WIDTH  = 2 * QUAT_WIDTH + 1;
  localparam int DEN_WIDTH  = NRM_WIDTH + 1;
  localparam int REM_WIDTH  = ACC_WIDTH + 2;
  localparam int DIV_LAT    = VEC_WIDTH + 2;
  localparam int PIPE_LAT   = 4 + DIV_LAT;
endpackage
`default_nettype wire

@@ hw/rtl/qvr_div.sv @@
// Pipelined rounding divider with saturation, one quotient bit per stage.
`default_nettype none
module qvr_div
  import qvr_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [ACC_WIDTH-1:0] acc,
  input  wire logic        [NRM_WIDTH-1:0] n,
  output logic signed      [VEC_WIDTH-1:0] q,
  output logic                             clip
);
  logic [REM_WIDTH-1:0] r  [0:VEC_WIDTH];
  logic [DEN_WIDTH-1:0] d  [0:VEC_WIDTH];
  logic [VEC_WIDTH-1:0] qv [0:VEC_WIDTH];
  logic                 sg [0:VEC_WIDTH];
  logic                 ov [0:VEC_WIDTH];

  logic [ACC_WIDTH-1:0] mag;
  logic [REM_WIDTH-1:0] num;
  logic [DEN_WIDTH-1:0] den;
  logic [REM_WIDTH-1:0] dsh [1:VEC_WIDTH];
  logic                 ge  [1:VEC_WIDTH];
  logic [VEC_WIDTH-1:0] lim, val;
  logic                 clip_c;

  always_comb begin
    mag = acc[ACC_WIDTH-1] ? ACC_WIDTH'(-acc) : ACC_WIDTH'(acc);
    // round half away: (2|a| + n) / 2n
    num = (REM_WIDTH'(mag) << 1) + REM_WIDTH'(n);
    den = {n, 1'b0};
    for (int i = 1; i <= VEC_WIDTH; i++) begin
      dsh[i] = REM_WIDTH'(d[i-1]) << (VEC_WIDTH - i);
      ge[i]  = r[i-1] >= dsh[i];
    end
    lim    = sg[VEC_WIDTH] ? {1'b1, {(VEC_WIDTH-1){1'b0}}} : {1'b0, {(VEC_WIDTH-1){1'b1}}};
    clip_c = ov[VEC_WIDTH] | (qv[VEC_WIDTH] > lim);
    val    = clip_c ? lim : qv[VEC_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= num;
      d[0]  <= den;
      qv[0] <= '0;
      sg[0] <= acc[ACC_WIDTH-1];
      ov[0] <= num >= (REM_WIDTH'(den) << VEC_WIDTH);
      for (int i = 1; i <= VEC_WIDTH; i++) begin
        r[i]  <= ge[i] ? r[i-1] - dsh[i] : r[i-1];
        d[i]  <= d[i-1];
        qv[i] <= qv[i-1] | (VEC_WIDTH'(ge[i]) << (VEC_WIDTH - i));
        sg[i] <= sg[i-1];
        ov[i] <= ov[i-1];
      end
      q    <= sg[VEC_WIDTH] ? -val : val;
      clip <= clip_c;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/quaternion_vector_rotation_unit.sv @@
// Throughput: one beat per cycle; the whole pipe holds while the output beat is stalled.
// Stages: pair products, matrix, matrix-vector multiply, sums, then a bit-per-stage divider.
// Reset clears the valid bits only; no other state.
`default_nettype none
module quaternion_vector_rotation_unit
  import qvr_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [QUAT_WIDTH-1:0] quat_w,
  input  wire logic signed [QUAT_WIDTH-1:0] quat_x,
  input  wire logic signed [QUAT_WIDTH-1:0] quat_y,
  input  wire logic signed [QUAT_WIDTH-1:0] quat_z,
  input  wire logic signed [VEC_WIDTH-1:0]  vec_x,
  input  wire logic signed [VEC_WIDTH-1:0]  vec_y,
  input  wire logic signed [VEC_WIDTH-1:0]  vec_z,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [VEC_WIDTH-1:0]      rot_x,
  output logic signed [VEC_WIDTH-1:0]      rot_y,
  output logic signed [VEC_WIDTH-1:0]      rot_z,
  output logic                             zero_quat,
  output logic                             saturated
);
  localparam int PW = 2 * QUAT_WIDTH;

  logic adv;
  logic vld [0:PIPE_LAT-1];
  logic zq  [0:PIPE_LAT-1];

  // stage 1
  logic signed [PW-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic signed [VEC_WIDTH-1:0] v1 [0:2];
  // stage 2
  logic signed [MAT_WIDTH-1:0] m [0:8];
  logic signed [VEC_WIDTH-1:0] v2 [0:2];
  logic        [NRM_WIDTH-1:0] n2;
  logic signed [MAT_WIDTH-1:0] nsum;
  // stage 3
  logic signed [PROD_WIDTH-1:0] p [0:8];
  logic        [NRM_WIDTH-1:0] n3;
  // stage 4
  logic signed [ACC_WIDTH-1:0] acc [0:2];
  logic        [NRM_WIDTH-1:0] n4;

  logic signed [VEC_WIDTH-1:0] q [0:2];
  logic                        clp [0:2];

  assign adv      = !vld[PIPE_LAT-1] || !out_stall;
  assign in_stall = !adv;
  assign nsum     = MAT_WIDTH'(ww) + MAT_WIDTH'(xx) + MAT_WIDTH'(yy) + MAT_WIDTH'(zz);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LAT; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < PIPE_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zq[0] <= (quat_w == '0) && (quat_x == '0) && (quat_y == '0) && (quat_z == '0);
      for (int i = 1; i < PIPE_LAT; i++) zq[i] <= zq[i-1];

      ww <= quat_w * quat_w;  xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;  zz <= quat_z * quat_z;
      xy <= quat_x * quat_y;  wz <= quat_w * quat_z;
      xz <= quat_x * quat_z;  wy <= quat_w * quat_y;
      yz <= quat_y * quat_z;  wx <= quat_w * quat_x;
      v1[0] <= vec_x;  v1[1] <= vec_y;  v1[2] <= vec_z;

      m[0] <= MAT_WIDTH'(ww) + MAT_WIDTH'(xx) - MAT_WIDTH'(yy) - MAT_WIDTH'(zz);
      m[1] <= (MAT_WIDTH'(xy) - MAT_WIDTH'(wz)) <<< 1;
      m[2] <= (MAT_WIDTH'(xz) + MAT_WIDTH'(wy)) <<< 1;
      m[3] <= (MAT_WIDTH'(xy) + MAT_WIDTH'(wz)) <<< 1;
      m[4] <= MAT_WIDTH'(ww) - MAT_WIDTH'(xx) + MAT_WIDTH'(yy) - MAT_WIDTH'(zz);
      m[5] <= (MAT_WIDTH'(yz) - MAT_WIDTH'(wx)) <<< 1;
      m[6] <= (MAT_WIDTH'(xz) - MAT_WIDTH'(wy)) <<< 1;
      m[7] <= (MAT_WIDTH'(yz) + MAT_WIDTH'(wx)) <<< 1;
      m[8] <= MAT_WIDTH'(ww) - MAT_WIDTH'(xx) - MAT_WIDTH'(yy) + MAT_WIDTH'(zz);
      n2   <= nsum[NRM_WIDTH-1:0];
      for (int c = 0; c < 3; c++) v2[c] <= v1[c];

      for (int k = 0; k < 9; k++) p[k] <= m[k] * v2[k % 3];
      n3 <= n2;

      for (int c = 0; c < 3; c++)
        acc[c] <= ACC_WIDTH'(p[3*c]) + ACC_WIDTH'(p[3*c+1]) + ACC_WIDTH'(p[3*c+2]);
      n4 <= n3;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    qvr_div u_div (
      .clk  (clk),
      .en   (adv),
      .acc  (acc[c]),
      .n    (n4),
      .q    (q[c]),
      .clip (clp[c])
    );
  end

  assign out_valid = vld[PIPE_LAT-1];
  assign zero_quat = zq[PIPE_LAT-1];
  assign rot_x     = zero_quat ? '0 : q[0];
  assign rot_y     = zero_quat ? '0 : q[1];
  assign rot_z     = zero_quat ? '0 : q[2];
  assign saturated = !zero_quat && (clp[0] || clp[1] || clp[2]);
endmodule
`default_nettype wire

@@ hw/rtl/qvr_checker.sv @@
// Port-level checks for the quaternion rotation unit, bound to the top level.
`default_nettype none
`include "quaternion_vector_rotation_unit_defines.svh"
module qvr_checker
  import qvr_pkg::*;
(
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic signed [QUAT_WIDTH-1:0] quat_w,
  input wire logic signed [QUAT_WIDTH-1:0] quat_x,
  input wire logic signed [QUAT_WIDTH-1:0] quat_y,
  input wire logic signed [QUAT_WIDTH-1:0] quat_z,
  input wire logic signed [VEC_WIDTH-1:0]  vec_x,
  input wire logic signed [VEC_WIDTH-1:0]  vec_y,
  input wire logic signed [VEC_WIDTH-1:0]  vec_z,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic signed [VEC_WIDTH-1:0] rot_x,
  input wire logic signed [VEC_WIDTH-1:0] rot_y,
  input wire logic signed [VEC_WIDTH-1:0] rot_z,
  input wire logic                        zero_quat,
  input wire logic                        saturated
);
  // stalled result beat holds
  `QVR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(rot_x) && $stable(rot_y) && $stable(rot_z) && $stable(saturated), "stalled result beat changed")
  // zero quaternion gives a clean zero result
  `QVR_ASSERT(a_zero_res, out_valid && zero_quat |-> rot_x == '0 && rot_y == '0 && rot_z == '0 && !saturated, "zero quaternion result not zero")
  // input side only stalls behind a stalled result
  `QVR_ASSERT(a_in_stall, in_stall |-> out_valid && out_stall, "input stalled without output stall")
  `QVR_ASSERT_RST(a_rst_empty, rst |=> !out_valid, "result valid right after reset")
endmodule

bind quaternion_vector_rotation_unit qvr_checker u_qvr_checker (.*);
`default_nettype wire
